/* sv/ihex_pkg.sv */
// Shared definitions for the Intel HEX record parser.
// Holds the line position width, status codes, character codes, the result record type
// and the hex digit decode. No dependencies.
package ihex_pkg;

   localparam int LINE_POS_BITS = 10;

   localparam logic [1:0] STATUS_DATA      = 2'd0;
   localparam logic [1:0] STATUS_NO_COLON  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [7:0] KIND_DATA     = 8'h00;
   localparam logic [7:0] KIND_EXT_ADDR = 8'h04;

   // character positions within a line
   localparam int POS_COUNT_LO  = 2;
   localparam int POS_OFFSET_HI = 3;
   localparam int POS_OFFSET_LO = 6;
   localparam int POS_KIND_HI   = 7;
   localparam int POS_KIND_LO   = 8;
   localparam int POS_PAYLOAD   = 9;
   localparam int POS_EXT_LO    = 12;

   typedef logic [LINE_POS_BITS-1:0] line_pos_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] record_address;
      logic [7:0]  byte_offset;
      logic [7:0]  data_byte;
      logic        last_in_record;
   } result_type;

   // bit 4 set means the character is not a hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end else begin
         r = 5'h10;
      end
      return r;
   endfunction

endpackage

/* sv/ihex_line_parser.sv */
// Per-character line parser: position tracking, field accumulation, address state.
// Produces at most one result record per transferred character.
// Depends on ihex_pkg.
module ihex_line_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                char_fire,
   input  logic [7:0]          text_char,
   output logic                res_valid,
   output ihex_pkg::result_type res
);
   import ihex_pkg::*;

   localparam line_pos_type POS_MAX = {LINE_POS_BITS{1'b1}};

   line_pos_type line_position_ff, line_position_in;
   logic [7:0]   record_length_ff, record_length_in;
   logic [7:0]   record_kind_ff, record_kind_in;
   logic [15:0]  upper_address_ff, upper_address_in;
   logic [15:0]  lower_address_ff, lower_address_in;
   logic [15:0]  field_acc_ff, field_acc_in;
   logic         field_invalid_ff, field_invalid_in;
   logic [7:0]   byte_count_ff, byte_count_in;
   logic         halted_ff, halted_in;

   logic [4:0]   nib;
   logic         field_start;
   logic [15:0]  field_value;
   logic [31:0]  full_address;
   logic         is_data_kind;

   assign nib          = hex_nibble(text_char);
   assign is_data_kind = (record_kind_ff == KIND_DATA);
   assign full_address = {upper_address_ff, lower_address_ff};

   always_comb begin
      line_position_in = line_position_ff;
      record_length_in = record_length_ff;
      record_kind_in   = record_kind_ff;
      upper_address_in = upper_address_ff;
      lower_address_in = lower_address_ff;
      field_acc_in     = field_acc_ff;
      field_invalid_in = field_invalid_ff;
      byte_count_in    = byte_count_ff;
      halted_in        = halted_ff;
      res_valid        = 1'b0;
      res              = '0;
      field_start      = 1'b0;
      field_value      = '0;

      if (char_fire && !halted_ff && text_char != CHAR_CR) begin
         if (line_position_ff == '0) begin
            if (text_char != CHAR_COLON) begin
               halted_in  = 1'b1;
               res_valid  = 1'b1;
               res.status = STATUS_NO_COLON;
            end else begin
               byte_count_in    = '0;
               line_position_in = line_pos_type'(1);
            end
         end else if (text_char == CHAR_LF) begin
            if (line_position_ff >= line_pos_type'(POS_PAYLOAD) && is_data_kind &&
                byte_count_ff < record_length_ff) begin
               res_valid          = 1'b1;
               res.status         = STATUS_TRUNCATED;
               res.record_address = full_address;
               res.byte_offset    = byte_count_ff;
            end
            line_position_in = '0;
            byte_count_in    = '0;
         end else if (line_position_ff != POS_MAX) begin
            // field starts: count, offset, kind, payload; each data byte after that
            field_start = (line_position_ff == line_pos_type'(1)) ||
                          (line_position_ff == line_pos_type'(POS_OFFSET_HI)) ||
                          (line_position_ff == line_pos_type'(POS_KIND_HI)) ||
                          (line_position_ff == line_pos_type'(POS_PAYLOAD)) ||
                          (line_position_ff > line_pos_type'(POS_PAYLOAD) &&
                           is_data_kind && line_position_ff[0]);
            if (field_start) begin
               field_acc_in     = {12'h000, nib[3:0]};
               field_invalid_in = nib[4];
            end else begin
               field_acc_in     = {field_acc_ff[11:0], nib[3:0]};
               field_invalid_in = field_invalid_ff | nib[4];
            end
            field_value = field_invalid_in ? 16'h0000 : field_acc_in;

            if (line_position_ff == line_pos_type'(POS_COUNT_LO)) begin
               record_length_in = field_value[7:0];
            end else if (line_position_ff == line_pos_type'(POS_OFFSET_LO)) begin
               lower_address_in = field_value;
            end else if (line_position_ff == line_pos_type'(POS_KIND_LO)) begin
               record_kind_in = field_value[7:0];
            end else if (line_position_ff > line_pos_type'(POS_PAYLOAD)) begin
               if (record_kind_ff == KIND_EXT_ADDR &&
                   line_position_ff == line_pos_type'(POS_EXT_LO)) begin
                  upper_address_in = field_value;
               end else if (is_data_kind && !line_position_ff[0] &&
                            byte_count_ff < record_length_ff) begin
                  res_valid          = 1'b1;
                  res.status         = STATUS_DATA;
                  res.record_address = full_address;
                  res.byte_offset    = byte_count_ff;
                  res.data_byte      = field_value[7:0];
                  res.last_in_record = (byte_count_ff + 8'd1 == record_length_ff);
                  byte_count_in      = byte_count_ff + 8'd1;
               end
            end
            line_position_in = line_position_ff + line_pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_position_ff <= '0;
         record_length_ff <= '0;
         record_kind_ff   <= '0;
         upper_address_ff <= '0;
         lower_address_ff <= '0;
         field_acc_ff     <= '0;
         field_invalid_ff <= 1'b0;
         byte_count_ff    <= '0;
         halted_ff        <= 1'b0;
      end else begin
         line_position_ff <= line_position_in;
         record_length_ff <= record_length_in;
         record_kind_ff   <= record_kind_in;
         upper_address_ff <= upper_address_in;
         lower_address_ff <= lower_address_in;
         field_acc_ff     <= field_acc_in;
         field_invalid_ff <= field_invalid_in;
         byte_count_ff    <= byte_count_in;
         halted_ff        <= halted_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_no_result_when_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced while halted");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= record_length_ff)
      else $error("emitted more bytes than record length");

   a_halt_reports: assert property (@(posedge clock) disable iff (reset)
      (!halted_ff && halted_in) |-> (res_valid && res.status == STATUS_NO_COLON))
      else $error("halt entered without a missing-colon result");
`endif

endmodule

/* sv/intel_hex_record_parser.sv */
// Top level of the Intel HEX record parser: character channel in, result records out.
// Instantiates ihex_line_parser and holds the result register. Depends on ihex_pkg.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | req_text_char
//   rsp     | rsp_valid/rsp_ready  | rsp_status, rsp_record_address, rsp_byte_offset,
//           |                      | rsp_data_byte, rsp_last_in_record
//
// One character per cycle while req_ready is high; a result appears in the cycle after the character that makes it.
// The parser state updates in the cycle of the transfer; the result register sits after it.
// req_ready drops only while a held result is not taken by rsp_ready.
// Synchronous reset clears the line state, addresses and the halt flag.
// After a line without a leading colon the block reports once and ignores input until reset.
module intel_hex_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_record_address,
   output logic [7:0]  rsp_byte_offset,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_in_record
);
   import ihex_pkg::*;

   logic       char_fire;
   logic       res_valid;
   result_type res;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign char_fire = req_valid && req_ready;

   ihex_line_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .char_fire (char_fire),
      .text_char (req_text_char),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_valid_in = res_valid || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_record_address = out_ff.record_address;
   assign rsp_byte_offset    = out_ff.byte_offset;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_last_in_record = out_ff.last_in_record;

endmodule

/* sim/intel_hex_record_parser_tb.sv */
// Self-checking testbench for intel_hex_record_parser.
// Sends Intel HEX text one character per transfer and checks each result record against
// a line parser kept in the testbench. Depends on ihex_pkg and the DUT.
module intel_hex_record_parser_tb;
   import ihex_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int POS_COUNT_HI    = 1;
   localparam int POS_MAX         = (1 << LINE_POS_BITS) - 1;
   localparam int NOT_HEX         = 16;
   localparam int RANDOM_CHARS    = 450;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 1000;

   localparam logic [7:0] KIND_END_OF_FILE = 8'h01;

   typedef enum {DIGITS_UPPER, DIGITS_LOWER, DIGITS_MIXED} digit_case_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [7:0]  req_text_char = 8'h00;
   logic        rsp_ready     = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_record_address;
   logic [7:0]  rsp_byte_offset;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_in_record;

   intel_hex_record_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_char      (req_text_char),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_record_address (rsp_record_address),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_in_record (rsp_last_in_record)
   );

   always #HALF_PERIOD clock = ~clock;

   // line parser state, mirrors the block
   int          line_pos   = 0;
   logic [7:0]  rec_length = '0;
   logic [7:0]  rec_kind   = '0;
   logic [15:0] upper_addr = '0;
   logic [15:0] lower_addr = '0;
   logic [15:0] field_acc  = '0;
   logic        field_bad  = 1'b0;
   logic [7:0]  bytes_done = '0;
   logic        halted     = 1'b0;
   result_type  expected_records[$];

   int          failures    = 0;
   int          quiet_cycles = 0;
   int          chars_sent  = 0;

   // stimulus controls
   logic [7:0]     line_text[$];
   digit_case_type digit_case       = DIGITS_UPPER;
   int             corrupt_pct      = 0;
   int             cr_pct           = 0;
   logic           sender_idle_on   = 1'b0;
   logic           receiver_idle_on = 1'b0;
   logic           hold_off_request = 1'b0;

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return NOT_HEX;
   endfunction

   function automatic void decode_char(input logic [7:0] c);
      int          nib;
      logic        field_start;
      logic [15:0] value;
      result_type  r;
      r = '0;
      if (halted || c == CHAR_CR) return;
      if (line_pos == 0) begin
         if (c != CHAR_COLON) begin
            halted = 1'b1;
            r.status = STATUS_NO_COLON;
            expected_records.push_back(r);
         end else begin
            bytes_done = '0;
            line_pos = 1;
         end
         return;
      end
      if (c == CHAR_LF) begin
         if (line_pos >= POS_PAYLOAD && rec_kind == KIND_DATA && bytes_done < rec_length) begin
            r.status = STATUS_TRUNCATED;
            r.record_address = {upper_addr, lower_addr};
            r.byte_offset = bytes_done;
            expected_records.push_back(r);
         end
         line_pos = 0;
         bytes_done = '0;
         return;
      end
      if (line_pos >= POS_MAX) return;
      nib = digit_value(c);
      field_start = line_pos == POS_COUNT_HI || line_pos == POS_OFFSET_HI ||
                    line_pos == POS_KIND_HI || line_pos == POS_PAYLOAD ||
                    (line_pos > POS_PAYLOAD && rec_kind == KIND_DATA &&
                     (line_pos - POS_PAYLOAD) % 2 == 0);
      if (field_start) begin
         field_acc = {12'h000, nib[3:0]};
         field_bad = (nib == NOT_HEX);
      end else begin
         field_acc = {field_acc[11:0], nib[3:0]};
         field_bad = field_bad || (nib == NOT_HEX);
      end
      value = field_bad ? 16'h0000 : field_acc;
      if (line_pos == POS_COUNT_LO) begin
         rec_length = value[7:0];
      end else if (line_pos == POS_OFFSET_LO) begin
         lower_addr = value;
      end else if (line_pos == POS_KIND_LO) begin
         rec_kind = value[7:0];
      end else if (line_pos > POS_PAYLOAD) begin
         if (rec_kind == KIND_EXT_ADDR && line_pos == POS_EXT_LO) begin
            upper_addr = value;
         end else if (rec_kind == KIND_DATA && (line_pos - POS_PAYLOAD) % 2 == 1 &&
                      bytes_done < rec_length) begin
            r.status = STATUS_DATA;
            r.record_address = {upper_addr, lower_addr};
            r.byte_offset = bytes_done;
            r.data_byte = value[7:0];
            r.last_in_record = (bytes_done + 8'd1 == rec_length);
            expected_records.push_back(r);
            bytes_done = bytes_done + 8'd1;
         end
      end
      line_pos = line_pos + 1;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_record();
      result_type want;
      if (expected_records.size() == 0) begin
         $display("%0t: result with nothing expected: expected none actual status %0d addr %h",
                  $time, rsp_status, rsp_record_address);
         failures++;
         return;
      end
      want = expected_records.pop_front();
      compare_field("status", 32'(want.status), 32'(rsp_status));
      compare_field("record_address", want.record_address, rsp_record_address);
      compare_field("byte_offset", 32'(want.byte_offset), 32'(rsp_byte_offset));
      compare_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
      compare_field("last_in_record", 32'(want.last_in_record), 32'(rsp_last_in_record));
   endfunction

   // values sampled here are the ones seen by the block at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_record();
         if (req_valid && req_ready) decode_char(req_text_char);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] junk_char(input logic skip_hex);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CHAR_LF || c == CHAR_CR || (skip_hex && digit_value(c) != NOT_HEX));
      return c;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] nib);
      logic lower;
      if (corrupt_pct > 0 && $urandom_range(0, 99) < corrupt_pct) return junk_char(1'b1);
      lower = (digit_case == DIGITS_LOWER) ||
              (digit_case == DIGITS_MIXED && $urandom_range(0, 1) == 1);
      if (nib < 10) return "0" + nib;
      return (lower ? "a" : "A") + nib - 8'd10;
   endfunction

   function automatic void add_char(input logic [7:0] c);
      line_text.push_back(c);
   endfunction

   function automatic void add_hex(input logic [31:0] value, input int digits);
      for (int i = digits - 1; i >= 0; i--) line_text.push_back(digit_char(value[4*i +: 4]));
   endfunction

   function automatic void add_header(input logic [7:0] count, input logic [15:0] offset,
                                      input logic [7:0] kind);
      add_char(CHAR_COLON);
      add_hex(32'(count), 2);
      add_hex(32'(offset), 4);
      add_hex(32'(kind), 2);
   endfunction

   function automatic void add_checksum();
      add_hex($urandom_range(0, 255), 2);
   endfunction

   function automatic void add_data_record(input int count);
      add_header(8'(count), 16'($urandom_range(0, 65535)), KIND_DATA);
      repeat (count) add_hex($urandom_range(0, 255), 2);
      add_checksum();
   endfunction

   // valid stays high between back-to-back transfers; it drops only for a gap
   task automatic send_char(input logic [7:0] c);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_char <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_line();
      add_char(CHAR_LF);
      foreach (line_text[i]) begin
         if (cr_pct > 0 && $urandom_range(0, 99) < cr_pct) send_char(CHAR_CR);
         send_char(line_text[i]);
      end
      line_text.delete();
   endtask

   function automatic void build_random_line();
      int         pick;
      int         count;
      logic [7:0] kind;
      pick = $urandom_range(0, 99);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
      if (pick < 55) begin
         add_data_record(count);
      end else if (pick < 70) begin
         add_header(8'h02, 16'($urandom_range(0, 65535)), KIND_EXT_ADDR);
         if ($urandom_range(0, 4) == 0) begin
            add_hex($urandom, $urandom_range(0, 3));
         end else begin
            add_hex($urandom_range(0, 65535), 4);
            add_checksum();
         end
      end else if (pick < 82) begin
         // data line cut short, possibly mid-byte
         count = $urandom_range(1, 16);
         add_header(8'(count), 16'($urandom_range(0, 65535)), KIND_DATA);
         repeat ($urandom_range(0, 2 * count - 1)) add_hex($urandom_range(0, 15), 1);
      end else if (pick < 88) begin
         add_char(CHAR_COLON);
         add_hex($urandom, $urandom_range(0, 7));
      end else if (pick < 94) begin
         do begin
            kind = 8'($urandom_range(0, 255));
         end while (kind == KIND_DATA || kind == KIND_EXT_ADDR);
         add_header(8'(count), 16'($urandom_range(0, 65535)), kind);
         repeat (2 * count + 2) add_hex($urandom_range(0, 15), 1);
      end else begin
         add_char(CHAR_COLON);
         repeat ($urandom_range(0, 30)) add_char(junk_char(1'b0));
      end
   endfunction

   task automatic test_plain_records();
      digit_case = DIGITS_UPPER;
      add_header(8'h02, 16'h0000, KIND_EXT_ADDR);
      add_hex(32'hABCD, 4);
      add_checksum();
      send_line();
      add_header(8'h03, 16'h1234, KIND_DATA);
      add_hex(32'h007FFF, 6);
      add_checksum();
      add_char(CHAR_CR);
      send_line();
      digit_case = DIGITS_LOWER;
      add_header(8'h02, 16'hFFFF, KIND_DATA);
      add_hex(32'hABCD, 4);
      add_checksum();
      send_line();
      digit_case = DIGITS_UPPER;
      add_header(8'h00, 16'h0010, KIND_DATA);
      add_checksum();
      send_line();
      add_header(8'h00, 16'h0000, KIND_END_OF_FILE);
      add_checksum();
      send_line();
   endtask

   task automatic test_bad_digits();
      // count reads as zero, so the payload is ignored
      add_char(CHAR_COLON);
      add_char("0");
      add_char("G");
      add_hex(32'h0100, 4);
      add_hex(32'(KIND_DATA), 2);
      add_hex(32'h1122, 4);
      send_line();
      // kind reads as zero, so the line is a data record
      add_char(CHAR_COLON);
      add_hex(32'h02, 2);
      add_hex(32'h0200, 4);
      add_char("Z");
      add_char("4");
      add_hex(32'h3344, 4);
      send_line();
      // offset and one data byte hold a non-hex character
      add_char(CHAR_COLON);
      add_hex(32'h02, 2);
      add_char(8'h80);
      add_hex(32'h123, 3);
      add_hex(32'(KIND_DATA), 2);
      add_char("1");
      add_char("x");
      add_hex(32'h5A, 2);
      send_line();
      // bad digit in an extended address clears the upper half
      add_header(8'h02, 16'h0000, KIND_EXT_ADDR);
      add_char("F");
      add_char(CHAR_COLON);
      add_hex(32'hFF, 2);
      send_line();
      add_data_record(2);
      send_line();
   endtask

   task automatic test_short_lines();
      add_header(8'h04, 16'h4000, KIND_DATA);
      add_hex(32'hA1B2, 4);
      add_hex(32'h7, 1);
      send_line();
      add_header(8'h03, 16'h5000, KIND_DATA);
      send_line();
      // header stops early: count kept, no result
      add_char(CHAR_COLON);
      add_hex(32'h0312, 4);
      send_line();
      add_char(CHAR_COLON);
      add_hex(32'h0500000, 7);
      send_line();
      add_header(8'h02, 16'h0000, KIND_EXT_ADDR);
      add_hex(32'h12, 2);
      send_line();
      add_header(8'h01, 16'h0042, KIND_DATA);
      add_hex(32'hC3, 2);
      add_checksum();
      repeat (6) add_char(junk_char(1'b0));
      send_line();
   endtask

   task automatic test_extremes();
      add_header(8'h02, 16'h0000, KIND_EXT_ADDR);
      add_hex(32'hFFFF, 4);
      add_checksum();
      send_line();
      // largest count and offset; the line ends after a few bytes
      add_header(8'hFF, 16'hFFFF, KIND_DATA);
      for (int b = 0; b < 8; b++) add_hex(32'(b), 2);
      send_line();
      add_header(8'h02, 16'h0000, KIND_EXT_ADDR);
      add_hex(32'h0000, 4);
      add_checksum();
      send_line();
   endtask

   task automatic test_random_lines();
      int start;
      start = chars_sent;
      digit_case = DIGITS_MIXED;
      cr_pct = 3;
      while (chars_sent - start < RANDOM_CHARS) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         corrupt_pct = ($urandom_range(0, 4) == 0) ? 10 : 0;
         build_random_line();
         send_line();
      end
      corrupt_pct = 0;
      cr_pct = 0;
   endtask

   task automatic test_output_stall();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      hold_off_request = 1'b1;
      add_data_record(24);
      send_line();
   endtask

   task automatic test_missing_colon();
      logic [7:0] c;
      repeat (3) begin
         add_data_record($urandom_range(1, 8));
         send_line();
      end
      if ($urandom_range(0, 1) == 0) begin
         c = CHAR_LF;
      end else begin
         do begin
            c = 8'($urandom_range(0, 255));
         end while (c == CHAR_COLON || c == CHAR_CR);
      end
      add_char(c);
      send_line();
      // halted: nothing below may produce a result
      add_data_record(3);
      send_line();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_plain_records();
      test_bad_digits();
      test_short_lines();
      test_extremes();
      test_random_lines();
      test_output_stall();
      test_missing_colon();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
